// ===== src/sarr_pkg.sv =====
// ----------------------------------------------------------------------------
// sarr_pkg
// Shared types and constants of the selective acknowledgement receive reorder
// block.
// ----------------------------------------------------------------------------
package sarr_pkg;

  localparam int unsigned SLOTS_DEF   = 16;
  localparam int unsigned DRAIN_LIMIT = 16;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned TAG_W       = 8;
  localparam int unsigned WIN_W       = 16;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [PADDR_W-1:0] ADDR_WINDOW = 3'd0;
  localparam logic [WIN_W-1:0]   WINDOW_RST  = 16'd16;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_SYNACK  = 2'd2,
    KIND_FINACK  = 2'd3
  } kind_e;

  typedef struct packed {
    logic             hit;
    logic             free;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } chain_t;

  typedef struct packed {
    logic [SEQ_W-1:0] key;
    logic             clear;
    logic             store;
    logic             take;
    logic             any_match;
    logic [SEQ_W-1:0] wseq;
    logic [LEN_W-1:0] wlen;
    logic [TAG_W-1:0] wtag;
  } ctl_t;

endpackage

// ===== src/selective_ack_receive_reorder.sv =====
// ----------------------------------------------------------------------------
// selective_ack_receive_reorder
// Receive-side segment sequencer with a reorder store and selective acks.
// ----------------------------------------------------------------------------
// One segment header enters per input transfer; each result leaves as one
// output transfer, with last_result_o marking the final one of a segment.
// The advertised window is written over the APB port at address 0.
// A segment is taken only when the sequencer is idle and the output register
// is free or being emptied. Simple cases give their single result from the
// output register in the cycle after the input transfer. An in-order segment
// gives its delivery, then one buffered successor per cycle out of the cell
// row while the receiver does not stall, at most DRAIN_LIMIT of them, then
// the ack. A FIN gives an ack and then a FIN+ACK. Reset clears the connection,
// the expected sequence and all slot valid bits. When the receiver stalls, the
// output register holds its result and the sequencer waits.
// ----------------------------------------------------------------------------
module selective_ack_receive_reorder
  import sarr_pkg::*;
#(
  parameter int unsigned REORDER_SLOTS = sarr_pkg::SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         checksum_ok_i,
  input  logic [2:0]                   flag_bits_i,
  input  logic [sarr_pkg::SEQ_W-1:0]   seq_number_i,
  input  logic [sarr_pkg::LEN_W-1:0]   payload_length_i,
  input  logic [sarr_pkg::TAG_W-1:0]   payload_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   result_kind_o,
  output logic [sarr_pkg::SEQ_W-1:0]   ack_value_o,
  output logic [sarr_pkg::SEQ_W-1:0]   sack_value_o,
  output logic [sarr_pkg::WIN_W-1:0]   window_value_o,
  output logic [sarr_pkg::SEQ_W-1:0]   deliver_seq_o,
  output logic [sarr_pkg::LEN_W-1:0]   deliver_length_o,
  output logic [sarr_pkg::TAG_W-1:0]   deliver_tag_o,
  output logic                         store_full_o,
  output logic                         is_connected_o,
  output logic                         last_result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sarr_pkg::PADDR_W-1:0] paddr,
  input  logic [sarr_pkg::PDATA_W-1:0] pwdata,
  output logic [sarr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int unsigned CNT_W = $clog2(DRAIN_LIMIT + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DRAIN  = 3'b010,
    S_FINACK = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [SEQ_W-1:0] exp_q, exp_d;
  logic             link_q, link_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIN_W-1:0] win_q;

  logic             ov_q, ov_d;
  kind_e            kind_q, kind_d;
  logic [SEQ_W-1:0] ack_q, ack_d, sack_q, sack_d, dseq_q, dseq_d;
  logic [LEN_W-1:0] dlen_q, dlen_d;
  logic [TAG_W-1:0] dtag_q, dtag_d;
  logic             full_q, full_d, conn_q, conn_d, last_q, last_d;

  logic             out_free, accept, emit, link_n, has_data;
  ctl_t             ctl;
  chain_t           chain [REORDER_SLOTS+1];

  assign chain[0] = '0;

  for (genvar g = 0; g < REORDER_SLOTS; g++) begin : g_cell
    sarr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign has_data   = (payload_length_i != '0);
  assign link_n     = link_q || has_data;

  always_comb begin
    state_d = state_q;
    exp_d   = exp_q;
    link_d  = link_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    kind_d  = KIND_ACK;
    ack_d   = '0;
    sack_d  = '0;
    dseq_d  = '0;
    dlen_d  = '0;
    dtag_d  = '0;
    full_d  = 1'b0;
    conn_d  = link_q;
    last_d  = 1'b1;
    ctl           = '0;
    ctl.key       = (state_q == S_DRAIN) ? exp_q : seq_number_i;
    ctl.any_match = chain[REORDER_SLOTS].hit;
    ctl.wseq      = seq_number_i;
    ctl.wlen      = payload_length_i;
    ctl.wtag      = payload_tag_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept && checksum_ok_i) begin
          if (flag_bits_i[0]) begin
            exp_d     = seq_number_i + 1'b1;
            link_d    = 1'b0;
            ctl.clear = 1'b1;
            emit      = 1'b1;
            kind_d    = KIND_SYNACK;
            ack_d     = seq_number_i + 1'b1;
            conn_d    = 1'b0;
          end else if (!link_q && flag_bits_i[1] && !has_data) begin
            link_d = 1'b1;
          end else if (flag_bits_i[2]) begin
            exp_d     = seq_number_i + 1'b1;
            link_d    = 1'b0;
            ctl.clear = 1'b1;
            emit      = 1'b1;
            ack_d     = seq_number_i + 1'b1;
            conn_d    = 1'b0;
            last_d    = 1'b0;
            state_d   = S_FINACK;
          end else if (link_n && has_data) begin
            link_d = 1'b1;
            conn_d = 1'b1;
            emit   = 1'b1;
            if (seq_number_i == exp_q) begin
              kind_d  = KIND_DELIVER;
              dseq_d  = seq_number_i;
              dlen_d  = payload_length_i;
              dtag_d  = payload_tag_i;
              last_d  = 1'b0;
              exp_d   = exp_q + {{(SEQ_W-LEN_W){1'b0}}, payload_length_i};
              cnt_d   = '0;
              state_d = S_DRAIN;
            end else if (seq_number_i > exp_q) begin
              ack_d = exp_q;
              if (chain[REORDER_SLOTS].hit || chain[REORDER_SLOTS].free) begin
                ctl.store = 1'b1;
                sack_d    = seq_number_i;
              end else begin
                full_d = 1'b1;
              end
            end else begin
              ack_d = exp_q;
            end
          end else begin
            link_d = link_n;
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (chain[REORDER_SLOTS].hit && (cnt_q < CNT_W'(DRAIN_LIMIT))) begin
            ctl.take = 1'b1;
            kind_d   = KIND_DELIVER;
            dseq_d   = chain[REORDER_SLOTS].seq;
            dlen_d   = chain[REORDER_SLOTS].len;
            dtag_d   = chain[REORDER_SLOTS].tag;
            last_d   = 1'b0;
            exp_d    = exp_q + {{(SEQ_W-LEN_W){1'b0}}, chain[REORDER_SLOTS].len};
            cnt_d    = cnt_q + 1'b1;
          end else begin
            ack_d   = exp_q;
            state_d = S_IDLE;
          end
        end
      end
      S_FINACK: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = KIND_FINACK;
          ack_d   = exp_q;
          conn_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (emit) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      exp_q   <= '0;
      link_q  <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      win_q   <= WINDOW_RST;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      link_q  <= link_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (psel && penable && pwrite && (paddr == ADDR_WINDOW)) begin
        win_q <= pwdata[WIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      ack_q  <= ack_d;
      sack_q <= sack_d;
      dseq_q <= dseq_d;
      dlen_q <= dlen_d;
      dtag_q <= dtag_d;
      full_q <= full_d;
      conn_q <= conn_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign result_kind_o    = kind_q;
  assign ack_value_o      = ack_q;
  assign sack_value_o     = sack_q;
  assign window_value_o   = win_q;
  assign deliver_seq_o    = dseq_q;
  assign deliver_length_o = dlen_q;
  assign deliver_tag_o    = dtag_q;
  assign store_full_o     = full_q;
  assign is_connected_o   = conn_q;
  assign last_result_o    = last_q;
  assign pready           = 1'b1;
  assign prdata = (paddr == ADDR_WINDOW) ? {{(PDATA_W-WIN_W){1'b0}}, win_q} : '0;

  a_deliver_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_DELIVER) |-> !last_result_o)
    else $error("delivery marked as final result");

  a_close_disconnected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((result_kind_o == KIND_FINACK) || (result_kind_o == KIND_SYNACK))
    |-> !is_connected_o && last_result_o)
    else $error("SYN+ACK or FIN+ACK with wrong connection or last flag");

  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DRAIN_LIMIT))
    else $error("drain count beyond limit");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input accepted while sequencer busy");

endmodule

// ===== src/sarr_cell.sv =====
// ----------------------------------------------------------------------------
// sarr_cell
// One slot of the out-of-order store. It compares its sequence with the
// broadcast key and passes the first-hit and first-free search to its neighbor.
// ----------------------------------------------------------------------------
module sarr_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sarr_pkg::ctl_t   ctl_i,
  input  sarr_pkg::chain_t chain_i,
  output sarr_pkg::chain_t chain_o
);
  import sarr_pkg::*;

  logic             valid_q, valid_d;
  logic [SEQ_W-1:0] seq_q;
  logic [LEN_W-1:0] len_q;
  logic [TAG_W-1:0] tag_q;
  logic             match, sel_hit, sel_free, wr;

  assign match    = valid_q && (seq_q == ctl_i.key);
  assign sel_hit  = match && !chain_i.hit;
  assign sel_free = !valid_q && !chain_i.free;
  assign wr       = ctl_i.store && (ctl_i.any_match ? sel_hit : sel_free);

  always_comb begin
    chain_o.hit  = chain_i.hit | match;
    chain_o.free = chain_i.free | !valid_q;
    chain_o.seq  = sel_hit ? seq_q : chain_i.seq;
    chain_o.len  = sel_hit ? len_q : chain_i.len;
    chain_o.tag  = sel_hit ? tag_q : chain_i.tag;
  end

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (wr) begin
      valid_d = 1'b1;
    end else if (ctl_i.take && sel_hit) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr && !ctl_i.clear) begin
      seq_q <= ctl_i.wseq;
      len_q <= ctl_i.wlen;
      tag_q <= ctl_i.wtag;
    end
  end

endmodule
